// ----- rtl/core/rce_pkg.sv -----
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types and constants for the rgb roberts cross edge detector.
// ----------------------------------------------------------------------------
package rce_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int FW_W        = 11;
   localparam int FH_W        = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] EDGE_CAP = 8'd255;

   // six channel differences of up to 255 each
   localparam int SUM_W = 11;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_data_type;

   typedef struct packed {
      logic [7:0] edge_value;
      logic       row_end;
      logic       frame_end;
   } rsp_data_type;

   typedef struct packed {
      req_data_type upper_left;
      req_data_type upper;
      req_data_type left;
      req_data_type cur;
      logic         row_end;
      logic         frame_end;
   } window_type;

endpackage

// ----- rtl/core/roberts_cross_edge_rgb.sv -----
// ----------------------------------------------------------------------------
// roberts_cross_edge_rgb
// Roberts cross edge detector over an rgb raster stream with a one-line buffer.
//
//   channel   ports                                   moves
//   req       req_push / req_full / req_data          one rgb pixel per beat
//   rsp       rsp_pop / rsp_empty / rsp_data          one edge result per beat
//   csr       csr_wr_en / csr_index / csr_wr_data     frame width, frame height
//
// one pixel per cycle sustained while req_full is low; a result reaches rsp
// through the line buffer read, window queue and output register.
// synchronous reset clears counters and queue; the line buffer is not
// cleared, each row only reads entries written by the row above it.
// a stalled rsp side fills the four-entry window queue and raises req_full.
// ----------------------------------------------------------------------------
module roberts_cross_edge_rgb (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  rce_pkg::req_data_type             req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output rce_pkg::rsp_data_type             rsp_data,
   input  logic                              csr_wr_en,
   input  logic [rce_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rce_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   logic                             win_push, q_pop, q_empty;
   rce_pkg::window_type              win_data, q_data;
   logic [rce_pkg::QCNT_W-1:0]       q_count;

   rce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_count     (q_count),
      .win_push    (win_push),
      .win_data    (win_data)
   );

   rce_win_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (win_push),
      .push_data (win_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data),
      .count     (q_count)
   );

   rce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/rce_front.sv -----
// ----------------------------------------------------------------------------
// rce_front
// Pixel intake: raster counters, line buffer and 2x2 window assembly.
// ----------------------------------------------------------------------------
module rce_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  rce_pkg::req_data_type               req_data,
   input  logic                                csr_wr_en,
   input  logic [rce_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rce_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  logic [rce_pkg::QCNT_W-1:0]          q_count,
   output logic                                win_push,
   output rce_pkg::window_type                 win_data
);

   logic [rce_pkg::FW_W-1:0]  frame_width_ff;
   logic [rce_pkg::FH_W-1:0]  frame_height_ff;
   logic [rce_pkg::COL_W-1:0] col_ff, col_in, col_eff, col_last;
   logic [rce_pkg::ROW_W-1:0] row_ff, row_in, row_eff, row_last;
   logic                      last_col, last_row, accept;

   logic                      s1_valid_ff, s1_prod_ff, s1_row_end_ff, s1_frame_end_ff;
   rce_pkg::req_data_type     s1_cur_ff, upper_ff, left_ff, upper_left_ff;
   rce_pkg::req_data_type     line_mem [rce_pkg::MAX_WIDTH];

   always_comb begin
      if (frame_width_ff < rce_pkg::FW_W'(2)) begin
         col_last = rce_pkg::COL_W'(1);
      end else if (frame_width_ff > rce_pkg::FW_W'(rce_pkg::MAX_WIDTH)) begin
         col_last = rce_pkg::COL_W'(rce_pkg::MAX_WIDTH - 1);
      end else begin
         col_last = rce_pkg::COL_W'(frame_width_ff - rce_pkg::FW_W'(1));
      end
      if (frame_height_ff < rce_pkg::FH_W'(2)) begin
         row_last = rce_pkg::ROW_W'(1);
      end else if (frame_height_ff > rce_pkg::FH_W'(rce_pkg::MAX_HEIGHT)) begin
         row_last = rce_pkg::ROW_W'(rce_pkg::MAX_HEIGHT - 1);
      end else begin
         row_last = rce_pkg::ROW_W'(frame_height_ff - rce_pkg::FH_W'(1));
      end
   end

   always_comb begin
      col_eff  = (col_ff >= col_last) ? col_last : col_ff;
      row_eff  = (row_ff >= row_last) ? row_last : row_ff;
      last_col = (col_eff == col_last);
      last_row = (row_eff == row_last);
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_eff + rce_pkg::ROW_W'(1);
      end else begin
         col_in = col_eff + rce_pkg::COL_W'(1);
         row_in = row_eff;
      end
   end

   // the staged item pushes into the queue unconditionally
   always_comb begin
      req_full = ({1'b0, q_count} + (rce_pkg::QCNT_W + 1)'(s1_prod_ff))
                 >= (rce_pkg::QCNT_W + 1)'(rce_pkg::QUEUE_DEPTH);
      accept   = req_push && !req_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rce_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= rce_pkg::FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rce_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= rce_pkg::FW_W'(csr_wr_data);
            end
            rce_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wr_data;
            end
            default: begin
            end
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffer, read before write at the same column
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_ff          <= line_mem[col_eff];
         line_mem[col_eff] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_prod_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_prod_ff  <= accept && (col_eff != '0) && (row_eff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff       <= req_data;
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else if (s1_valid_ff) begin
         left_ff       <= s1_cur_ff;
         upper_left_ff <= upper_ff;
      end
   end

   always_comb begin
      win_push            = s1_prod_ff;
      win_data.upper_left = upper_left_ff;
      win_data.upper      = upper_ff;
      win_data.left       = left_ff;
      win_data.cur        = s1_cur_ff;
      win_data.row_end    = s1_row_end_ff;
      win_data.frame_end  = s1_frame_end_ff;
   end

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && last_col && last_row |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap at frame end");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_wr_en && last_col && !last_row
      |=> col_ff == '0 && row_ff == $past(row_eff) + rce_pkg::ROW_W'(1))
      else $error("row counter did not advance at row end");

endmodule

// ----- rtl/core/rce_win_queue.sv -----
// ----------------------------------------------------------------------------
// rce_win_queue
// Short fifo of assembled windows between intake and edge compute.
// ----------------------------------------------------------------------------
module rce_win_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  rce_pkg::window_type           push_data,
   input  logic                          pop,
   output logic                          empty,
   output rce_pkg::window_type           pop_data,
   output logic [rce_pkg::QCNT_W-1:0]    count
);

   rce_pkg::window_type                entries_ff [rce_pkg::QUEUE_DEPTH];
   logic [rce_pkg::QPTR_W-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [rce_pkg::QCNT_W-1:0]         count_ff;
   logic                               do_pop;

   always_comb begin
      empty    = (count_ff == '0);
      do_pop   = pop && !empty;
      pop_data = entries_ff[rd_ptr_ff];
      count    = count_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + rce_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + rce_pkg::QPTR_W'(1);
         end
         count_ff <= count_ff + rce_pkg::QCNT_W'(push) - rce_pkg::QCNT_W'(do_pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rce_pkg::QCNT_W'(rce_pkg::QUEUE_DEPTH))
      else $error("window queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != rce_pkg::QCNT_W'(rce_pkg::QUEUE_DEPTH))
      else $error("push into full window queue");

endmodule

// ----- rtl/core/rce_back.sv -----
// ----------------------------------------------------------------------------
// rce_back
// Edge compute: diagonal absolute differences, saturation, output register.
// ----------------------------------------------------------------------------
module rce_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  rce_pkg::window_type     q_data,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output rce_pkg::rsp_data_type   rsp_data
);

   logic                          out_valid_ff;
   rce_pkg::rsp_data_type         out_data_ff, out_data_in;
   logic [rce_pkg::SUM_W-1:0]     sum;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   always_comb begin
      sum = rce_pkg::SUM_W'(abs_diff(q_data.upper_left.red,   q_data.cur.red))
          + rce_pkg::SUM_W'(abs_diff(q_data.upper_left.green, q_data.cur.green))
          + rce_pkg::SUM_W'(abs_diff(q_data.upper_left.blue,  q_data.cur.blue))
          + rce_pkg::SUM_W'(abs_diff(q_data.upper.red,        q_data.left.red))
          + rce_pkg::SUM_W'(abs_diff(q_data.upper.green,      q_data.left.green))
          + rce_pkg::SUM_W'(abs_diff(q_data.upper.blue,       q_data.left.blue));
      out_data_in.edge_value = (sum > rce_pkg::SUM_W'(rce_pkg::EDGE_CAP)) ? rce_pkg::EDGE_CAP
                                                                          : sum[7:0];
      out_data_in.row_end    = q_data.row_end;
      out_data_in.frame_end  = q_data.frame_end;
      q_pop                  = !q_empty && (!out_valid_ff || rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (q_pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.frame_end |-> out_data_ff.row_end)
      else $error("frame end without row end");

endmodule
